/* design/ede_pkg.sv */
// Shared constants and codes for the edit distance engine.
`timescale 1ns / 1ps

package ede_pkg;

  // Field widths of the channel payloads
  localparam int MODE_W   = 2;
  localparam int SYMBOL_W = 16;
  localparam int DIST_W   = 7;

  // Defaults for the top-level parameters
  localparam int MAX_LEN_DEF   = 64;
  localparam int CHAR_BITS_DEF = 16;

  // Command codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE     = 2'd2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [SYMBOL_W-1:0] symbol_t;
  typedef logic [DIST_W-1:0]   dist_t;

endpackage

/* design/ede_channels.sv */
// Valid/ready channel interfaces for the command input and the result output.
`timescale 1ns / 1ps

interface ede_in_if import ede_pkg::*; ();
  logic    valid;
  logic    ready;
  mode_t   mode;
  symbol_t symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface ede_out_if import ede_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t distance;
  logic  overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

/* design/ede_cell.sv */
// Shared cell unit: one step of the edit distance recurrence.
`timescale 1ns / 1ps

module ede_cell #(
  parameter int VAL_W  = 7,
  parameter int CHAR_W = 16
) (
  input  logic [VAL_W-1:0]  up_val,
  input  logic [VAL_W-1:0]  left_val,
  input  logic [VAL_W-1:0]  diag_val,
  input  logic [CHAR_W-1:0] char_a,
  input  logic [CHAR_W-1:0] char_b,
  output logic [VAL_W-1:0]  cell_val
);

  logic [VAL_W:0] del_cost;
  logic [VAL_W:0] ins_cost;
  logic [VAL_W:0] sub_cost;
  logic [VAL_W:0] min_a;
  logic [VAL_W:0] min_b;

  // Form the three candidate costs one bit wider than the row values
  assign del_cost = {1'b0, up_val} + (VAL_W+1)'(1);
  assign ins_cost = {1'b0, left_val} + (VAL_W+1)'(1);
  assign sub_cost = {1'b0, diag_val} + (VAL_W+1)'(char_a != char_b);

  // Pick the cheapest; the minimum always fits the row width
  assign min_a    = (del_cost < ins_cost) ? del_cost : ins_cost;
  assign min_b    = (min_a < sub_cost) ? min_a : sub_cost;
  assign cell_val = min_b[VAL_W-1:0];

endmodule

/* design/edit_distance_engine.sv */
// Edit distance engine: loads two strings and computes their Levenshtein distance.
// Loads (mode 0/1) and unused mode 3 are taken without leaving idle; ready stays high in idle.
// Compute steps one cell per cycle through the shared cell unit, with a row-start
// state before each row; if a string is empty it goes straight to the finish state.
// Ready is low during a compute; loads go on while a result waits on the output.
// Reset clears the state, counts, indices, drop flag and output valid; string and row memories hold.
`timescale 1ns / 1ps

module edit_distance_engine import ede_pkg::*; #(
  parameter int MAX_LEN   = MAX_LEN_DEF,
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ede_in_if.sink      in_ch,
  ede_out_if.source   out_ch
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_CELL = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Control and working registers
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] diag_r, diag_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] res_r, res_nxt;
  logic [CW-1:0] cnt1_r, cnt1_nxt;
  logic [CW-1:0] cnt2_r, cnt2_nxt;
  logic          drop_r, drop_nxt;
  logic          out_valid_r, out_valid_nxt;
  dist_t         out_dist_r, out_dist_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  // Memories and their ports
  logic [CHAR_BITS-1:0] first_mem  [MAX_LEN];
  logic [CHAR_BITS-1:0] second_mem [MAX_LEN];
  logic [CW-1:0]        row_mem    [MAX_LEN+1];

  logic                 first_we, second_we, row_we;
  logic [AW-1:0]        first_ra, second_ra;
  logic [CW-1:0]        row_ra;
  logic [CHAR_BITS-1:0] first_q, second_q;
  logic [CW-1:0]        row_q;
  logic [CHAR_BITS-1:0] sym_k;

  logic          in_fire;
  logic [CW-1:0] up_v;
  logic [CW-1:0] cell_val;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_fire         = in_ch.valid && (state_r == ST_IDLE);
  assign sym_k           = CHAR_BITS'(in_ch.symbol);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.distance = out_dist_r;
  assign out_ch.overflow = out_ovf_r;

  // Read addresses: current row's character, next cell's column and row entry
  assign first_ra  = AW'(i_r - CW'(1));
  assign second_ra = (state_r == ST_CELL) ? AW'(j_r) : '0;
  assign row_ra    = (state_r == ST_ROW) ? CW'(1) :
                     ((j_r == cnt2_r) ? '0 : j_r + CW'(1));

  // First row of the matrix is the column index itself
  assign up_v = (i_r == CW'(1)) ? j_r : row_q;

  ede_cell #(
    .VAL_W  (CW),
    .CHAR_W (CHAR_BITS)
  ) u_cell (
    .up_val   (up_v),
    .left_val (left_r),
    .diag_val (diag_r),
    .char_a   (first_q),
    .char_b   (second_q),
    .cell_val (cell_val)
  );

  // String stores: write on load, registered read
  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[cnt1_r[AW-1:0]] <= sym_k;
    end
    first_q <= first_mem[first_ra];
  end

  always_ff @(posedge clk) begin
    if (second_we) begin
      second_mem[cnt2_r[AW-1:0]] <= sym_k;
    end
    second_q <= second_mem[second_ra];
  end

  // Working row: write the finished cell, read the next one
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[j_r] <= cell_val;
    end
    row_q <= row_mem[row_ra];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    res_nxt       = res_r;
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    out_ovf_nxt   = out_ovf_r;
    first_we      = 1'b0;
    second_we     = 1'b0;
    row_we        = 1'b0;

    // Drop the result once it is transferred
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.mode)
            MODE_LOAD_FIRST: begin
              if (cnt1_r < CW'(MAX_LEN)) begin
                first_we = 1'b1;
                cnt1_nxt = cnt1_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            MODE_LOAD_SECOND: begin
              if (cnt2_r < CW'(MAX_LEN)) begin
                second_we = 1'b1;
                cnt2_nxt  = cnt2_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            MODE_COMPUTE: begin
              if (cnt1_r == '0) begin
                res_nxt   = cnt2_r;
                state_nxt = ST_FIN;
              end else if (cnt2_r == '0) begin
                res_nxt   = cnt1_r;
                state_nxt = ST_FIN;
              end else begin
                i_nxt     = CW'(1);
                state_nxt = ST_ROW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROW: begin
        // Start a row: left edge is i, diagonal is the previous row's edge
        j_nxt     = CW'(1);
        diag_nxt  = i_r - CW'(1);
        left_nxt  = i_r;
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        row_we   = 1'b1;
        left_nxt = cell_val;
        diag_nxt = up_v;
        if (j_r == cnt2_r) begin
          if (i_r == cnt1_r) begin
            res_nxt   = cell_val;
            state_nxt = ST_FIN;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_ROW;
          end
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      ST_FIN: begin
        // Hand the result to the output register, then clear both strings
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = DIST_W'(res_r);
          out_ovf_nxt   = drop_r;
          cnt1_nxt      = '0;
          cnt2_nxt      = '0;
          drop_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  // Working values and result payload
  always_ff @(posedge clk) begin
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    res_r      <= res_nxt;
    out_dist_r <= out_dist_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule
